// File: sv/adc_table_to_signed_temperature_macros.svh
// Assertion macros used by the thermistor lookup controller.
// Expects clk and arst_n in the scope of each use.
`ifndef ADC_TABLE_TO_SIGNED_TEMPERATURE_MACROS_SVH
`define ADC_TABLE_TO_SIGNED_TEMPERATURE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ATST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/atst_pkg.sv
// Shared widths, voltage table, digit helpers and controller/datapath structs.
// No dependencies; every other file but the assertion macros header imports this package.
`default_nettype none
package atst_pkg;

	localparam int TABLE_DEPTH      = 61;
	localparam int NEGATIVE_ENTRIES = 10;
	localparam int STORED_ENTRIES   = 61;
	localparam int SEARCH_LIMIT     = (TABLE_DEPTH < STORED_ENTRIES) ? TABLE_DEPTH
	                                                                 : STORED_ENTRIES;
	localparam int IDX_W            = $clog2(SEARCH_LIMIT);

	localparam int CODE_W  = 8;
	localparam int SCALE_W = 5;
	localparam int PROD_W  = 13;
	localparam int VOLT_W  = 13;
	localparam int MAG_W   = 6;
	localparam int TENS_W  = 3;
	localparam int ONES_W  = 4;
	localparam int DIFF_W  = MAG_W + 1;

	localparam int ADC_SCALE_RESET = 19;
	localparam int DIGIT_BASE      = 10;

	typedef struct packed {
		logic load;    // capture code, form product, restart search
		logic step;    // advance to next table entry
		logic stop;    // freeze search, record hit flag
		logic commit;  // update held value and result register
	} atst_cmd_t;

	typedef struct packed {
		logic match;   // current entry at or below the product
		logic last;    // current entry is the last one searched
	} atst_sts_t;

	typedef struct packed {
		logic              is_negative;
		logic [MAG_W-1:0]  magnitude;
		logic [TENS_W-1:0] tens_digit;
		logic [ONES_W-1:0] ones_digit;
		logic              in_range;
	} atst_result_t;

	// Descending thermistor voltage table; unstored slots never match.
	function automatic logic [VOLT_W-1:0] volt_entry(input logic [5:0] idx);
		logic [VOLT_W-1:0] v;
		case (idx)
			6'd0:  v = 13'd4132;  6'd1:  v = 13'd4098;  6'd2:  v = 13'd4063;
			6'd3:  v = 13'd4026;  6'd4:  v = 13'd3988;  6'd5:  v = 13'd3949;
			6'd6:  v = 13'd3908;  6'd7:  v = 13'd3866;  6'd8:  v = 13'd3823;
			6'd9:  v = 13'd3779;  6'd10: v = 13'd3733;  6'd11: v = 13'd3686;
			6'd12: v = 13'd3639;  6'd13: v = 13'd3590;  6'd14: v = 13'd3540;
			6'd15: v = 13'd3489;  6'd16: v = 13'd3437;  6'd17: v = 13'd3385;
			6'd18: v = 13'd3331;  6'd19: v = 13'd3277;  6'd20: v = 13'd3222;
			6'd21: v = 13'd3166;  6'd22: v = 13'd3110;  6'd23: v = 13'd3054;
			6'd24: v = 13'd2997;  6'd25: v = 13'd2940;  6'd26: v = 13'd2882;
			6'd27: v = 13'd2824;  6'd28: v = 13'd2767;  6'd29: v = 13'd2709;
			6'd30: v = 13'd2651;  6'd31: v = 13'd2593;  6'd32: v = 13'd2536;
			6'd33: v = 13'd2478;  6'd34: v = 13'd2421;  6'd35: v = 13'd2365;
			6'd36: v = 13'd2309;  6'd37: v = 13'd2253;  6'd38: v = 13'd2198;
			6'd39: v = 13'd2143;  6'd40: v = 13'd2089;  6'd41: v = 13'd2036;
			6'd42: v = 13'd1984;  6'd43: v = 13'd1932;  6'd44: v = 13'd1881;
			6'd45: v = 13'd1831;  6'd46: v = 13'd1782;  6'd47: v = 13'd1734;
			6'd48: v = 13'd1686;  6'd49: v = 13'd1640;  6'd50: v = 13'd1594;
			6'd51: v = 13'd1550;  6'd52: v = 13'd1506;  6'd53: v = 13'd1464;
			6'd54: v = 13'd1422;  6'd55: v = 13'd1381;  6'd56: v = 13'd1341;
			6'd57: v = 13'd1303;  6'd58: v = 13'd1265;  6'd59: v = 13'd1228;
			6'd60: v = 13'd1192;
			default: v = '1;  // above any product
		endcase
		return v;
	endfunction

	// Tens digit of a 6-bit value by compare chain.
	function automatic logic [TENS_W-1:0] tens_of(input logic [MAG_W-1:0] m);
		logic [TENS_W-1:0] t;
		if (m >= MAG_W'(60)) t = TENS_W'(6);
		else if (m >= MAG_W'(50)) t = TENS_W'(5);
		else if (m >= MAG_W'(40)) t = TENS_W'(4);
		else if (m >= MAG_W'(30)) t = TENS_W'(3);
		else if (m >= MAG_W'(20)) t = TENS_W'(2);
		else if (m >= MAG_W'(10)) t = TENS_W'(1);
		else t = '0;
		return t;
	endfunction

	function automatic logic [ONES_W-1:0] ones_of(input logic [MAG_W-1:0] m,
	                                             input logic [TENS_W-1:0] t);
		logic [MAG_W-1:0] r;
		r = m - MAG_W'(MAG_W'(t) * MAG_W'(DIGIT_BASE));
		return ONES_W'(r);
	endfunction

endpackage
`default_nettype wire

// File: sv/atst_in_if.sv
// Input channel: valid/ready handshake carrying one converter code.
// Depends on atst_pkg for the code width.
`default_nettype none
interface atst_in_if;
	import atst_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] adc_code;

	modport source (output valid, output adc_code, input ready);
	modport sink (input valid, input adc_code, output ready);
endinterface
`default_nettype wire

// File: sv/atst_out_if.sv
// Output channel: valid/ready handshake carrying one temperature result.
// Depends on atst_pkg for field widths.
`default_nettype none
interface atst_out_if;
	import atst_pkg::*;
	logic              valid;
	logic              ready;
	logic              is_negative;
	logic [MAG_W-1:0]  magnitude;
	logic [TENS_W-1:0] tens_digit;
	logic [ONES_W-1:0] ones_digit;
	logic              in_range;

	modport source (output valid, output is_negative, output magnitude,
		output tens_digit, output ones_digit, output in_range, input ready);
	modport sink (input valid, input is_negative, input magnitude,
		input tens_digit, input ones_digit, input in_range, output ready);
endinterface
`default_nettype wire

// File: sv/atst_dp.sv
// Datapath: scale register, product, table index, held temperature, result register.
// Depends on atst_pkg; driven by atst_ctrl through atst_cmd_t.
`default_nettype none
module atst_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire atst_pkg::atst_cmd_t        cmd,
	output atst_pkg::atst_sts_t             sts,
	input  wire logic [atst_pkg::CODE_W-1:0]  adc_code,
	input  wire logic                       cfg_we,
	input  wire logic [atst_pkg::SCALE_W-1:0] cfg_wdata,
	output atst_pkg::atst_result_t          result
);
	import atst_pkg::*;

	logic [SCALE_W-1:0] adc_scale_q;
	logic [PROD_W-1:0]  scaled_q;
	logic [IDX_W-1:0]   idx_q;
	logic               hit_q;
	logic [MAG_W-1:0]   held_mag_q;
	logic               held_neg_q;
	atst_result_t       result_q;

	logic [VOLT_W-1:0]  entry;
	logic [DIFF_W-1:0]  idx_x;
	logic [DIFF_W-1:0]  neg_x;
	logic [DIFF_W-1:0]  diff;
	logic               found_neg;
	logic [MAG_W-1:0]   next_mag;
	logic               next_neg;

	assign entry     = volt_entry(6'(idx_q));
	assign sts.match = ({1'b0, scaled_q} >= {1'b0, entry});
	assign sts.last  = (idx_q == IDX_W'(SEARCH_LIMIT - 1));

	// Map table index to signed temperature
	assign idx_x     = DIFF_W'(idx_q);
	assign neg_x     = DIFF_W'(NEGATIVE_ENTRIES);
	assign found_neg = (idx_x < neg_x);
	assign diff      = found_neg ? (neg_x - idx_x) : (idx_x - neg_x);
	assign next_mag  = hit_q ? diff[MAG_W-1:0] : held_mag_q;
	assign next_neg  = hit_q ? found_neg : held_neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_scale_q <= SCALE_W'(ADC_SCALE_RESET);
			idx_q       <= '0;
			hit_q       <= 1'b0;
			held_mag_q  <= '0;
			held_neg_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				adc_scale_q <= cfg_wdata;
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.stop) begin
				hit_q <= sts.match;
			end
			if (cmd.commit) begin
				held_mag_q <= next_mag;
				held_neg_q <= next_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scaled_q <= PROD_W'(adc_code) * PROD_W'(adc_scale_q);
		end
		if (cmd.commit) begin
			result_q.is_negative <= next_neg;
			result_q.magnitude   <= next_mag;
			result_q.tens_digit  <= tens_of(next_mag);
			result_q.ones_digit  <= ones_of(next_mag, tens_of(next_mag));
			result_q.in_range    <= hit_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

// File: sv/atst_ctrl.sv
// Controller: accepts a code, steps the table search, hands the result to the output.
// Depends on atst_pkg and the assertion macros header.
`default_nettype none
module atst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire atst_pkg::atst_sts_t sts,
	output atst_pkg::atst_cmd_t      cmd
);
	import atst_pkg::*;
	`include "adc_table_to_signed_temperature_macros.svh"

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.match || sts.last) begin
					cmd.stop = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EMIT: begin
				// hold until the result register can take a new transaction
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ATST_ASSERT_NEXT(a_accept_starts_search, in_valid && in_ready, state_q == ST_SEARCH, "accepted code did not start a search")
	`ATST_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid, "committed result not presented")
	`ATST_ASSERT_NOW(a_no_step_past_end, state_q == ST_SEARCH, !(cmd.step && sts.last), "search stepped past last entry")
	`ATST_ASSERT_NEXT(a_emit_waits, state_q == ST_EMIT && out_valid_q && !out_ready, state_q == ST_EMIT && out_valid, "result overwritten while output stalled")

endmodule
`default_nettype wire

// File: sv/adc_table_to_signed_temperature.sv
// A code is accepted only while idle; the controller then walks the table, comparing one
// table entry per cycle until an entry matches or the last one is reached, and commits the result
// once the output slot is free, so a new code is not taken before the last result is committed.
// Reset (arst_n low, asynchronous): scale returns to 19, held temperature to +0, output empty.
// Depends on atst_pkg, atst_in_if, atst_out_if, atst_ctrl and atst_dp.
`default_nettype none
module adc_table_to_signed_temperature (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	atst_in_if.sink                           sample,
	atst_out_if.source                        result,
	input  wire logic                         cfg_we,
	input  wire logic [atst_pkg::SCALE_W-1:0] cfg_wdata
);
	import atst_pkg::*;

	atst_cmd_t    cmd;
	atst_sts_t    sts;
	atst_result_t res;

	atst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	atst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.adc_code  (sample.adc_code),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (res)
	);

	assign result.is_negative = res.is_negative;
	assign result.magnitude   = res.magnitude;
	assign result.tens_digit  = res.tens_digit;
	assign result.ones_digit  = res.ones_digit;
	assign result.in_range    = res.in_range;

endmodule
`default_nettype wire
